FILE: design/shp_pkg.sv
package shp_pkg;

  localparam int unsigned SAMPLE_W         = 8;
  localparam int unsigned FRAME_WIDTH_W    = 12;
  localparam int unsigned FRAME_HEIGHT_W   = 13;
  localparam int unsigned CHANNEL_COUNT_W  = 3;
  localparam int unsigned ROW_W            = 12;
  localparam int unsigned CFG_INDEX_W      = 2;
  localparam int unsigned CFG_DATA_W       = 13;

  localparam int unsigned MAX_WIDTH_DEF    = 2048;
  localparam int unsigned MAX_CHANNELS_DEF = 4;
  localparam int unsigned MAX_HEIGHT       = 4096;
  localparam int unsigned MIN_FRAME        = 3;
  localparam int unsigned MIN_CHANNELS     = 1;

  localparam int unsigned FRAME_WIDTH_RST   = 640;
  localparam int unsigned FRAME_HEIGHT_RST  = 480;
  localparam int unsigned CHANNEL_COUNT_RST = 1;

  localparam int unsigned CENTRE_GAIN = 5;
  localparam int unsigned SAMPLE_MAX  = 255;
  localparam int unsigned ACC_W       = 12;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_FLUSH  = 1'b1
  } shp_mode_e;

  typedef struct packed {
    shp_mode_e             mode;
    logic [SAMPLE_W-1:0]   sample;
  } shp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   sharpened;
    logic                  frame_end;
  } shp_out_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
  } shp_cfg_t;

  // Operands of one result, handed from the front end to the arithmetic.
  typedef struct packed {
    logic [SAMPLE_W-1:0] centre;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] upper;
    logic [SAMPLE_W-1:0] lower;
    logic                zero;
    logic                frame_end;
  } shp_op_t;

endpackage

FILE: design/shp_chan_if.sv
interface shp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/shp_front.sv
module shp_front import shp_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  shp_chan_if.sink          in_i,
  shp_chan_if.sink          cfg_i,
  input  logic [QCNT_W-1:0] q_count_i,
  output logic              push_valid_o,
  output shp_op_t           push_op_o
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW         = $clog2(LINE_DEPTH);
  localparam int unsigned LW         = $clog2(LINE_DEPTH + 1);
  localparam int unsigned PW         = $clog2(LINE_DEPTH + MAX_CHANNELS + 2);
  localparam int unsigned CW         = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned WD         = 2 * MAX_CHANNELS;
  localparam int unsigned WIW        = $clog2(WD);

  // Configuration registers.
  logic [FRAME_WIDTH_W-1:0]   fw_q;
  logic [FRAME_HEIGHT_W-1:0]  fh_q;
  logic [CHANNEL_COUNT_W-1:0] cc_q;
  logic                       cfg_clear;

  // Derived frame geometry.
  logic [LW-1:0]             w;
  logic [FRAME_HEIGHT_W-1:0] h;
  logic [CW-1:0]             c;
  logic [LW-1:0]             len;
  logic [PW-1:0]             len_c;

  // Stream counters.
  logic [AW-1:0]    in_pos_q;
  logic [ROW_W-1:0] in_row_q;
  logic [AW-1:0]    out_pos_q;
  logic [ROW_W-1:0] out_row_q;
  logic [PW-1:0]    pending_q;

  logic [AW-1:0]             p;
  logic                      has_p;
  logic [PW-1:0]             s_inc;
  logic                      in_wrap;
  logic [FRAME_HEIGHT_W-1:0] in_row_inc;
  logic [PW-1:0]             pend_inc;
  logic                      emit_data;
  logic [FRAME_HEIGHT_W-1:0] out_row_inc;
  logic [PW-1:0]             out_pos_inc;
  logic                      out_wrap;
  logic                      interior;
  logic                      frame_end;
  logic                      flush_ok;
  logic                      in_ready;
  logic                      accept;
  logic                      data_acc;
  logic                      flush_acc;
  logic                      emit;

  // Second stage: line store read data and the centre-row window.
  logic                f1_data_q;
  logic                f1_push_q;
  logic                f1_has_p_q;
  logic [AW-1:0]       f1_p_q;
  logic                f1_live_q;
  logic                f1_frame_end_q;
  logic [SAMPLE_W-1:0] mid_s_rd_q;
  logic [SAMPLE_W-1:0] mid_p_rd_q;
  logic [SAMPLE_W-1:0] up_rd_q;
  logic [SAMPLE_W-1:0] win_q [WD];
  logic [WIW-1:0]      idx_c;
  logic [WIW-1:0]      idx_l;
  logic [SAMPLE_W-1:0] centre;
  logic [SAMPLE_W-1:0] left;

  logic [SAMPLE_W-1:0] middle_mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0] upper_mem  [LINE_DEPTH];

  assign cfg_i.ready = 1'b1;
  assign cfg_clear   = cfg_i.valid && (cfg_i.data.index == REG_FRAME_WIDTH ||
                                       cfg_i.data.index == REG_FRAME_HEIGHT ||
                                       cfg_i.data.index == REG_CHANNEL_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_W'(FRAME_WIDTH_RST);
      fh_q <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
      cc_q <= CHANNEL_COUNT_W'(CHANNEL_COUNT_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_FRAME_WIDTH:   fw_q <= cfg_i.data.value[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT:  fh_q <= cfg_i.data.value[FRAME_HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: cc_q <= cfg_i.data.value[CHANNEL_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values are clamped to the supported range.
  always_comb begin
    if (fw_q < FRAME_WIDTH_W'(MIN_FRAME)) begin
      w = LW'(MIN_FRAME);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w = LW'(MAX_WIDTH);
    end else begin
      w = LW'(fw_q);
    end
    if (fh_q < FRAME_HEIGHT_W'(MIN_FRAME)) begin
      h = FRAME_HEIGHT_W'(MIN_FRAME);
    end else if (32'(fh_q) > MAX_HEIGHT) begin
      h = FRAME_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h = fh_q;
    end
    if (cc_q < CHANNEL_COUNT_W'(MIN_CHANNELS)) begin
      c = CW'(MIN_CHANNELS);
    end else if (32'(cc_q) > MAX_CHANNELS) begin
      c = CW'(MAX_CHANNELS);
    end else begin
      c = CW'(cc_q);
    end
    len   = LW'(32'(w) * 32'(c));
    len_c = PW'(len) + PW'(c);
  end

  always_comb begin
    has_p       = PW'(in_pos_q) >= PW'(c);
    p           = has_p ? AW'(in_pos_q - AW'(c)) : '0;
    s_inc       = PW'(in_pos_q) + PW'(1);
    in_wrap     = s_inc >= PW'(len);
    in_row_inc  = FRAME_HEIGHT_W'(in_row_q) + FRAME_HEIGHT_W'(1);
    pend_inc    = pending_q + PW'(1);
    emit_data   = pend_inc > len_c;
    out_row_inc = FRAME_HEIGHT_W'(out_row_q) + FRAME_HEIGHT_W'(1);
    out_pos_inc = PW'(out_pos_q) + PW'(1);
    out_wrap    = out_pos_inc >= PW'(len);
    interior    = (out_row_q != '0) && (out_row_inc < h) &&
                  (PW'(out_pos_q) >= PW'(c)) &&
                  (PW'(out_pos_q) + PW'(c) < PW'(len));
    frame_end   = (out_row_inc >= h) && out_wrap;
    // A flush only drains the tail once the input side sits at a frame start.
    flush_ok    = (pending_q != '0) && (in_pos_q == '0) && (in_row_q == '0);
    in_ready    = (q_count_i + QCNT_W'(f1_push_q)) < QCNT_W'(QUEUE_DEPTH);
    accept      = in_i.valid && in_ready;
    data_acc    = accept && (in_i.data.mode == MODE_SAMPLE);
    flush_acc   = accept && (in_i.data.mode == MODE_FLUSH) && flush_ok;
    emit        = (data_acc && emit_data) || flush_acc;
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      in_row_q  <= '0;
      out_pos_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
      f1_data_q <= 1'b0;
      f1_push_q <= 1'b0;
    end else if (cfg_clear) begin
      in_pos_q  <= '0;
      in_row_q  <= '0;
      out_pos_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
      f1_data_q <= 1'b0;
      f1_push_q <= 1'b0;
    end else begin
      f1_data_q <= data_acc;
      f1_push_q <= emit;
      if (data_acc) begin
        in_pos_q <= in_wrap ? '0 : AW'(s_inc);
        if (in_wrap) begin
          in_row_q <= (in_row_inc >= h) ? '0 : ROW_W'(in_row_inc);
        end
      end
      if (emit) begin
        out_pos_q <= out_wrap ? '0 : AW'(out_pos_inc);
        if (out_wrap) begin
          out_row_q <= (out_row_inc >= h) ? '0 : ROW_W'(out_row_inc);
        end
      end
      // A data sample that releases a result leaves the pending count unchanged.
      if (data_acc && !emit_data) begin
        pending_q <= pend_inc;
      end else if (flush_acc) begin
        pending_q <= pending_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_has_p_q     <= has_p;
      f1_p_q         <= p;
      f1_live_q      <= (in_i.data.mode == MODE_SAMPLE) && has_p && interior;
      f1_frame_end_q <= frame_end;
    end
  end

  // The middle line is written in the accept cycle, so the next sample
  // already sees it when it reads its lower neighbor.
  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      mid_s_rd_q        <= middle_mem[in_pos_q];
      mid_p_rd_q        <= middle_mem[p];
      middle_mem[in_pos_q] <= in_i.data.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      up_rd_q <= upper_mem[p];
    end
    if (f1_data_q && f1_has_p_q) begin
      upper_mem[f1_p_q] <= centre;
    end
  end

  assign idx_c  = WIW'(32'(c) - 1);
  assign idx_l  = WIW'(2 * 32'(c) - 1);
  assign centre = win_q[idx_c];
  assign left   = win_q[idx_l];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WD; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_clear) begin
      for (int i = 0; i < WD; i++) begin
        win_q[i] <= '0;
      end
    end else if (f1_data_q) begin
      win_q[0] <= mid_s_rd_q;
      for (int i = 1; i < WD; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_comb begin
    push_valid_o        = f1_push_q;
    push_op_o.centre    = centre;
    push_op_o.left      = left;
    push_op_o.right     = mid_s_rd_q;
    push_op_o.upper     = up_rd_q;
    push_op_o.lower     = mid_p_rd_q;
    push_op_o.zero      = !f1_live_q;
    push_op_o.frame_end = f1_frame_end_q;
  end

endmodule

FILE: design/shp_queue.sv
module shp_queue import shp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  shp_op_t           push_op_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output shp_op_t           head_op_o,
  output logic [QCNT_W-1:0] count_o
);

  shp_op_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
    ptr_next = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

FILE: design/shp_back.sv
module shp_back import shp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  shp_op_t   head_op_i,
  output logic      pop_o,
  shp_chan_if.source out_o
);

  logic [ACC_W-1:0]    pos;
  logic [ACC_W-1:0]    neg;
  logic [ACC_W-1:0]    acc;
  logic [SAMPLE_W-1:0] value;
  logic                out_valid_q;
  shp_out_t            out_data_q;

  // acc is a two's complement value in -1020..1275.
  always_comb begin
    pos = ACC_W'(head_op_i.centre) * ACC_W'(CENTRE_GAIN);
    neg = ACC_W'(head_op_i.left) + ACC_W'(head_op_i.right) +
          ACC_W'(head_op_i.upper) + ACC_W'(head_op_i.lower);
    acc = pos - neg;
    if (head_op_i.zero || acc[ACC_W-1]) begin
      value = '0;
    end else if (acc > ACC_W'(SAMPLE_MAX)) begin
      value = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      value = acc[SAMPLE_W-1:0];
    end
  end

  assign pop_o = head_valid_i && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q.sharpened <= value;
      out_data_q.frame_end <= head_op_i.frame_end;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

FILE: design/sharpen_3x3_stencil_unit.sv
// Throughput: one input item per cycle while the queue has room, limited by the single write port of each line store.
// An accepted item that releases a result passes it through the front end's second stage, the queue and the output
// register to out_o; a sample's own result is released by the input width*channels+channels samples later.
// Reset: counters, window and output cleared, registers back to 640 x 480 x 1.
// The line stores are not cleared; entries read before being written only reach border results.
module sharpen_3x3_stencil_unit import shp_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  shp_chan_if.sink   in_i,
  shp_chan_if.sink   cfg_i,
  shp_chan_if.source out_o
);

  logic              push_valid;
  shp_op_t           push_op;
  logic              pop;
  logic              head_valid;
  shp_op_t           head_op;
  logic [QCNT_W-1:0] q_count;

  shp_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .q_count_i    (q_count),
    .push_valid_o (push_valid),
    .push_op_o    (push_op)
  );

  shp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_op_i    (push_op),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_op_o    (head_op),
    .count_o      (q_count)
  );

  shp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_op_i    (head_op),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
